FILE: rtl/hcpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcpe_pkg
// Shared constants for the cubic Hermite curve point evaluator: register
// indexes, configuration field widths and parameter defaults.
// ----------------------------------------------------------------------------
package hcpe_pkg;

    // Parameter defaults
    localparam int DEF_T_FRAC_BITS = 16;
    localparam int DEF_COORD_BITS  = 12;

    // Configuration port
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_START_X       = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_START_Y       = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_END_X         = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_END_Y         = 8'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_START_TAN_X   = 8'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_START_TAN_Y   = 8'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_END_TAN_X     = 8'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_END_TAN_Y     = 8'd7;

    // Field widths of the control points and tangents
    localparam int PT_W  = 10;
    localparam int TAN_W = 12;

    // Polynomial coefficient widths: a = 2P0-2P1+M0+M1, b = 3(P1-P0)-2M0-M1
    localparam int A_W = 14;
    localparam int B_W = 15;

    // Number of axes
    localparam int N_AXES = 2;

endpackage

FILE: rtl/hermite_curve_point_eval_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hermite_curve_point_eval_unit
// Evaluates a 2-D cubic Hermite curve at one parameter t per beat and
// returns the point truncated toward zero and saturated.
// An accepted input beat passes through every pipeline stage to m_tdata.
// Throughput: one beat per cycle while m_tready is high; each stage advances
// on its own, so the input keeps accepting into empty stages while the output beat is held.
// Reset (aresetn low, synchronous) empties the pipeline and clears all
// configuration registers to zero.
// ----------------------------------------------------------------------------
module hermite_curve_point_eval_unit #(
    parameter int T_FRAC_BITS = hcpe_pkg::DEF_T_FRAC_BITS,
    parameter int COORD_BITS  = hcpe_pkg::DEF_COORD_BITS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [hcpe_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [hcpe_pkg::CFG_DATA_W-1:0]        cfg_data,
    // Input stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((T_FRAC_BITS+8)/8)*8-1:0]       s_tdata,  // param_t
    // Result stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((2*COORD_BITS+7)/8)*8-1:0]      m_tdata   // point_x, point_y
);
    import hcpe_pkg::*;

    localparam int F      = T_FRAC_BITS;
    localparam int TW     = F + 1;
    localparam int T2W    = 2 * F + 1;
    localparam int T3W    = 3 * F + 1;
    localparam int PA_W   = A_W + T3W + 1;
    localparam int PB_W   = B_W + T2W + 1;
    localparam int PC_W   = TAN_W + TW + 1;
    localparam int SW     = 3 * F + 17;
    localparam int QW     = SW - 3 * F;
    localparam int NST    = 6;
    localparam int M_W    = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam logic [TW-1:0]  T_ONE  = TW'(1) << F;
    localparam logic [T2W-1:0] T2_ONE = T2W'(1) << (2 * F);
    localparam logic signed [QW-1:0] SAT_HI = QW'((2 ** (COORD_BITS - 1)) - 1);
    localparam logic signed [QW-1:0] SAT_LO = QW'(-(2 ** (COORD_BITS - 1)));

    // Configuration registers, index 0 is x and 1 is y
    logic        [PT_W-1:0]  start_pt_reg  [N_AXES];
    logic        [PT_W-1:0]  end_pt_reg    [N_AXES];
    logic signed [TAN_W-1:0] start_tan_reg [N_AXES];
    logic signed [TAN_W-1:0] end_tan_reg   [N_AXES];

    // Pipeline control
    logic [NST-1:0] valid_reg;
    logic [NST-1:0] stage_rdy;

    // Pipeline payload
    logic [TW-1:0]  t1_s1_reg, t1_s2_reg, t1_s3_reg;
    logic [T2W-1:0] t2_s2_reg, t2_s3_reg;
    logic [T3W-1:0] t3_s3_reg;
    logic signed [PA_W-1:0] pa_reg  [N_AXES];
    logic signed [PB_W-1:0] pb_reg  [N_AXES];
    logic signed [PC_W-1:0] pc_reg  [N_AXES];
    logic signed [SW-1:0]   sum_reg [N_AXES];
    logic [COORD_BITS-1:0]  point_reg  [N_AXES];
    logic [COORD_BITS-1:0]  point_next [N_AXES];

    logic signed [A_W-1:0] coef_a [N_AXES];
    logic signed [B_W-1:0] coef_b [N_AXES];
    logic [TW-1:0]         t_in;
    logic [TW-1:0]         t_clamped;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N_AXES; i++) begin
                start_pt_reg[i]  <= '0;
                end_pt_reg[i]    <= '0;
                start_tan_reg[i] <= '0;
                end_tan_reg[i]   <= '0;
            end
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                REG_START_X:     start_pt_reg[0]  <= cfg_data[PT_W-1:0];
                REG_START_Y:     start_pt_reg[1]  <= cfg_data[PT_W-1:0];
                REG_END_X:       end_pt_reg[0]    <= cfg_data[PT_W-1:0];
                REG_END_Y:       end_pt_reg[1]    <= cfg_data[PT_W-1:0];
                REG_START_TAN_X: start_tan_reg[0] <= $signed(cfg_data[TAN_W-1:0]);
                REG_START_TAN_Y: start_tan_reg[1] <= $signed(cfg_data[TAN_W-1:0]);
                REG_END_TAN_X:   end_tan_reg[0]   <= $signed(cfg_data[TAN_W-1:0]);
                REG_END_TAN_Y:   end_tan_reg[1]   <= $signed(cfg_data[TAN_W-1:0]);
                default: ;
            endcase
        end
    end

    // Power-basis coefficients. The user must change the configuration only while the pipeline
    // is empty (the block does not enforce this), so these are formed straight from the registers.
    always_comb begin
        logic signed [B_W-1:0] p0w, p1w, m0w, m1w, dp;
        for (int i = 0; i < N_AXES; i++) begin
            p0w = B_W'($signed({1'b0, start_pt_reg[i]}));
            p1w = B_W'($signed({1'b0, end_pt_reg[i]}));
            m0w = B_W'(start_tan_reg[i]);
            m1w = B_W'(end_tan_reg[i]);
            dp  = p1w - p0w;
            coef_a[i] = A_W'(m0w + m1w - (dp <<< 1));
            coef_b[i] = (dp <<< 1) + dp - (m0w <<< 1) - m1w;
        end
    end

    // A stage can load when it is empty or its content moves on.
    always_comb begin
        stage_rdy[NST-1] = !valid_reg[NST-1] || m_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            stage_rdy[k] = !valid_reg[k] || stage_rdy[k+1];
        end
    end

    assign s_tready = stage_rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_rdy[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (stage_rdy[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign t_in      = s_tdata[TW-1:0];
    assign t_clamped = (t_in > T_ONE) ? T_ONE : t_in;

    // Stage 1: clamp. Stage 2: t squared. Stage 3: t cubed.
    always_ff @(posedge aclk) begin
        if (stage_rdy[0]) begin
            t1_s1_reg <= t_clamped;
        end
        if (stage_rdy[1]) begin
            t1_s2_reg <= t1_s1_reg;
            t2_s2_reg <= T2W'({{F{1'b0}}, t1_s1_reg} * t1_s1_reg);
        end
        if (stage_rdy[2]) begin
            t1_s3_reg <= t1_s2_reg;
            t2_s3_reg <= t2_s2_reg;
            t3_s3_reg <= {{F{1'b0}}, t2_s2_reg} * t1_s2_reg;
        end
    end

    // Stage 4: coefficient products. Stage 5: aligned sum scaled by 2^(3F).
    always_ff @(posedge aclk) begin
        for (int i = 0; i < N_AXES; i++) begin
            if (stage_rdy[3]) begin
                pa_reg[i] <= coef_a[i] * $signed({1'b0, t3_s3_reg});
                pb_reg[i] <= coef_b[i] * $signed({1'b0, t2_s3_reg});
                pc_reg[i] <= start_tan_reg[i] * $signed({1'b0, t1_s3_reg});
            end
            if (stage_rdy[4]) begin
                sum_reg[i] <= SW'(pa_reg[i])
                            + (SW'(pb_reg[i]) <<< F)
                            + (SW'(pc_reg[i]) <<< (2 * F))
                            + (SW'($signed({1'b0, start_pt_reg[i]})) <<< (3 * F));
            end
        end
    end

    // Stage 6: drop the fraction toward zero and saturate.
    always_comb begin
        logic signed [QW-1:0] q_floor;
        logic signed [QW-1:0] q_trunc;
        logic                 round_up;
        for (int i = 0; i < N_AXES; i++) begin
            q_floor  = $signed(sum_reg[i][SW-1:3*F]);
            round_up = sum_reg[i][SW-1] && (|sum_reg[i][3*F-1:0]);
            q_trunc  = q_floor + $signed({{(QW-1){1'b0}}, round_up});
            if (q_trunc > SAT_HI) begin
                point_next[i] = SAT_HI[COORD_BITS-1:0];
            end else if (q_trunc < SAT_LO) begin
                point_next[i] = SAT_LO[COORD_BITS-1:0];
            end else begin
                point_next[i] = q_trunc[COORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_rdy[5]) begin
            for (int i = 0; i < N_AXES; i++) begin
                point_reg[i] <= point_next[i];
            end
        end
    end

    assign m_tvalid = valid_reg[NST-1];
    assign m_tdata  = M_W'({point_reg[1], point_reg[0]});

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> (valid_reg == '0))
        else $error("pipeline not empty after reset");

    a_t_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[0] |-> (t1_s1_reg <= T_ONE))
        else $error("clamped parameter exceeds one");

    a_t2_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[1] |-> (t2_s2_reg <= T2_ONE))
        else $error("t squared exceeds one");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && (valid_reg == '1)) |-> !s_tready)
        else $error("input accepted into a full stalled pipeline");

    a_sign_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_rdy[5] && valid_reg[4] && sum_reg[0][SW-1])
            |=> (point_reg[0][COORD_BITS-1] || (point_reg[0] == '0)))
        else $error("negative x sum produced a positive point");

endmodule
